// File: hw/rtl/fpd_pkg.sv
`timescale 1ns / 1ps

package fpd_pkg;

   localparam int TIME_W  = 32;
   localparam int ACCEL_W = 16;
   localparam int ALT_W   = 24;
   localparam int PHASE_W = 3;
   localparam int MAG_W   = 32;
   localparam int SQ_W    = 31;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 23;
   localparam int LEVEL_W    = 16;
   localparam int MS_W       = 16;
   localparam int COUNT_W    = 8;
   localparam int LAND_ALT_W = 23;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 8;

   localparam logic [PHASE_W-1:0] PH_GROUND  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_POWERED = 3'd1;
   localparam logic [PHASE_W-1:0] PH_COAST   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DESCEND = 3'd3;
   localparam logic [PHASE_W-1:0] PH_LANDED  = 3'd4;

   localparam logic [CSR_ADDR_W-1:0] CSR_LAUNCH_LEVEL  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CUTOFF_LEVEL  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_TIME     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_APOGEE_INTVL  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_APOGEE_COUNT  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_LAND_LEVEL    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_LAND_CONFIRM  = 3'd6;

   localparam logic [LEVEL_W-1:0]    RST_LAUNCH_LEVEL = 16'd3000;
   localparam logic [LEVEL_W-1:0]    RST_CUTOFF_LEVEL = 16'd1200;
   localparam logic [MS_W-1:0]       RST_HOLD_TIME    = 16'd100;
   localparam logic [MS_W-1:0]       RST_APOGEE_INTVL = 16'd100;
   localparam logic [COUNT_W-1:0]    RST_APOGEE_COUNT = 8'd3;
   localparam logic [LAND_ALT_W-1:0] RST_LAND_LEVEL   = 23'd100;
   localparam logic [MS_W-1:0]       RST_LAND_CONFIRM = 16'd5000;

   localparam logic [COUNT_W-1:0] FALL_MAX = 8'd255;

endpackage

// File: hw/rtl/flight_phase_detector_top.sv
`timescale 1ns / 1ps

// flight phase detector
// req channel: one sensor sample per request (timestamp, acceleration vector,
//   altitude in tdata, accelerometer-valid flag in tuser)
// rsp channel: one result per request, the phase after that sample and a
//   flag that the sample caused a phase change
// csr port: plain register writes, only while no request is in flight
// result path: a taken request passes the input register, square stage,
//   sum stage and state update into the result register, which drives
//   rsp_tvalid
// throughput: one request per cycle while rsp_tready does not stall; the state
//   update is combinational compares against the flight state registers
// reset: phase returns to ground idle, all timers and counters clear and the
//   registers take their default values
// rsp stall: the stages fill up behind the result register; req_tready drops
//   only once every stage holds a request
module flight_phase_detector_top
   import fpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // time_ms, accel_x, accel_y, accel_z, altitude
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // accel_valid
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // phase, phase_changed, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [LEVEL_W-1:0]    launch_level_ff, cutoff_level_ff;
   logic [MS_W-1:0]       hold_time_ff, apogee_intvl_ff, land_confirm_ff;
   logic [COUNT_W-1:0]    apogee_count_ff;
   logic [LAND_ALT_W-1:0] land_level_ff;
   logic [MAG_W-1:0]      launch_lim_ff, cutoff_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_level_ff <= RST_LAUNCH_LEVEL;
         cutoff_level_ff <= RST_CUTOFF_LEVEL;
         hold_time_ff    <= RST_HOLD_TIME;
         apogee_intvl_ff <= RST_APOGEE_INTVL;
         apogee_count_ff <= RST_APOGEE_COUNT;
         land_level_ff   <= RST_LAND_LEVEL;
         land_confirm_ff <= RST_LAND_CONFIRM;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LAUNCH_LEVEL: launch_level_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_CUTOFF_LEVEL: cutoff_level_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_HOLD_TIME:    hold_time_ff    <= csr_wdata[MS_W-1:0];
            CSR_APOGEE_INTVL: apogee_intvl_ff <= csr_wdata[MS_W-1:0];
            CSR_APOGEE_COUNT: apogee_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_LAND_LEVEL:   land_level_ff   <= csr_wdata[LAND_ALT_W-1:0];
            CSR_LAND_CONFIRM: land_confirm_ff <= csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   logic [MAG_W-1:0] launch_lim_in, cutoff_lim_in;
   assign launch_lim_in = MAG_W'(launch_level_ff) * MAG_W'(launch_level_ff);
   assign cutoff_lim_in = MAG_W'(cutoff_level_ff) * MAG_W'(cutoff_level_ff);

   always_ff @(posedge clock) begin
      launch_lim_ff <= launch_lim_in;
      cutoff_lim_ff <= cutoff_lim_in;
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic adv2, adv3, adv_out, req_accept;

   assign adv_out    = s3_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign adv3       = s2_valid_ff && (!s3_valid_ff || adv_out);
   assign adv2       = s1_valid_ff && (!s2_valid_ff || adv3);
   assign req_tready = !s1_valid_ff || adv2;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept)
            s1_valid_ff <= 1'b1;
         else if (adv2)
            s1_valid_ff <= 1'b0;
         if (adv2)
            s2_valid_ff <= 1'b1;
         else if (adv3)
            s2_valid_ff <= 1'b0;
         if (adv3)
            s3_valid_ff <= 1'b1;
         else if (adv_out)
            s3_valid_ff <= 1'b0;
         if (adv_out)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // stage 1: input register
   logic [TIME_W-1:0]         s1_time_ff;
   logic                      s1_av_ff;
   logic signed [ACCEL_W-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic signed [ALT_W-1:0]   s1_alt_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_time_ff <= req_tdata[31:0];
         s1_x_ff    <= req_tdata[47:32];
         s1_y_ff    <= req_tdata[63:48];
         s1_z_ff    <= req_tdata[79:64];
         s1_alt_ff  <= req_tdata[103:80];
         s1_av_ff   <= req_tuser;
      end
   end

   // stage 2: squares
   logic signed [MAG_W-1:0] prod_x, prod_y, prod_z;
   assign prod_x = MAG_W'(s1_x_ff) * MAG_W'(s1_x_ff);
   assign prod_y = MAG_W'(s1_y_ff) * MAG_W'(s1_y_ff);
   assign prod_z = MAG_W'(s1_z_ff) * MAG_W'(s1_z_ff);

   logic [TIME_W-1:0]       s2_time_ff;
   logic                    s2_av_ff;
   logic [SQ_W-1:0]         s2_sqx_ff, s2_sqy_ff, s2_sqz_ff;
   logic signed [ALT_W-1:0] s2_alt_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_time_ff <= s1_time_ff;
         s2_av_ff   <= s1_av_ff;
         s2_alt_ff  <= s1_alt_ff;
         s2_sqx_ff  <= prod_x[SQ_W-1:0];
         s2_sqy_ff  <= prod_y[SQ_W-1:0];
         s2_sqz_ff  <= prod_z[SQ_W-1:0];
      end
   end

   // stage 3: magnitude squared
   logic [MAG_W-1:0] mag_in;
   assign mag_in = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff} + {1'b0, s2_sqz_ff};

   logic [TIME_W-1:0]       s3_time_ff;
   logic                    s3_av_ff;
   logic [MAG_W-1:0]        s3_mag_ff;
   logic signed [ALT_W-1:0] s3_alt_ff;

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_time_ff <= s2_time_ff;
         s3_av_ff   <= s2_av_ff;
         s3_alt_ff  <= s2_alt_ff;
         s3_mag_ff  <= mag_in;
      end
   end

   // flight state
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic                    launch_run_ff, launch_run_in;
   logic [TIME_W-1:0]       launch_start_ff, launch_start_in;
   logic                    cutoff_run_ff, cutoff_run_in;
   logic [TIME_W-1:0]       cutoff_start_ff, cutoff_start_in;
   logic [TIME_W-1:0]       last_check_ff, last_check_in;
   logic signed [ALT_W-1:0] prev_alt_ff, prev_alt_in;
   logic [COUNT_W-1:0]      falling_ff, falling_in;
   logic                    land_run_ff, land_run_in;
   logic [TIME_W-1:0]       land_start_ff, land_start_in;
   logic [MAG_W-1:0]        held_mag_ff, held_mag_in;

   logic [TIME_W-1:0]  dt_launch, dt_cutoff, dt_check, dt_land;
   logic [COUNT_W-1:0] falling_inc;

   assign dt_launch   = s3_time_ff - launch_start_ff;
   assign dt_cutoff   = s3_time_ff - cutoff_start_ff;
   assign dt_check    = s3_time_ff - last_check_ff;
   assign dt_land     = s3_time_ff - land_start_ff;
   assign falling_inc = (falling_ff < FALL_MAX) ? falling_ff + 8'd1 : falling_ff;

   always_comb begin
      phase_in        = phase_ff;
      launch_run_in   = launch_run_ff;
      launch_start_in = launch_start_ff;
      cutoff_run_in   = cutoff_run_ff;
      cutoff_start_in = cutoff_start_ff;
      last_check_in   = last_check_ff;
      prev_alt_in     = prev_alt_ff;
      falling_in      = falling_ff;
      land_run_in     = land_run_ff;
      land_start_in   = land_start_ff;
      held_mag_in     = s3_av_ff ? s3_mag_ff : held_mag_ff;
      case (phase_ff)
         PH_GROUND: begin
            if (s3_av_ff) begin
               if (s3_mag_ff > launch_lim_ff) begin
                  if (!launch_run_ff) begin
                     launch_run_in   = 1'b1;
                     launch_start_in = s3_time_ff;
                  end else if (dt_launch >= {16'd0, hold_time_ff}) begin
                     phase_in = PH_POWERED;
                  end
               end else begin
                  launch_run_in = 1'b0;
               end
            end
         end
         PH_POWERED: begin
            if (held_mag_in <= cutoff_lim_ff) begin
               if (!cutoff_run_ff) begin
                  cutoff_run_in   = 1'b1;
                  cutoff_start_in = s3_time_ff;
               end else if (dt_cutoff >= {16'd0, hold_time_ff}) begin
                  phase_in = PH_COAST;
               end
            end else begin
               cutoff_run_in = 1'b0;
            end
         end
         PH_COAST: begin
            if (dt_check >= {16'd0, apogee_intvl_ff}) begin
               if (s3_alt_ff < prev_alt_ff) begin
                  falling_in = falling_inc;
                  if (falling_inc >= apogee_count_ff) begin
                     phase_in = PH_DESCEND;
                  end else begin
                     prev_alt_in   = s3_alt_ff;
                     last_check_in = s3_time_ff;
                  end
               end else begin
                  falling_in    = '0;
                  prev_alt_in   = s3_alt_ff;
                  last_check_in = s3_time_ff;
               end
            end
         end
         PH_DESCEND: begin
            if (s3_alt_ff < $signed({1'b0, land_level_ff})) begin
               if (!land_run_ff) begin
                  land_run_in   = 1'b1;
                  land_start_in = s3_time_ff;
               end else if (dt_land >= {16'd0, land_confirm_ff}) begin
                  phase_in = PH_LANDED;
               end
            end else begin
               land_run_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   logic rsp_changed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_GROUND;
         launch_run_ff   <= 1'b0;
         launch_start_ff <= '0;
         cutoff_run_ff   <= 1'b0;
         cutoff_start_ff <= '0;
         last_check_ff   <= '0;
         prev_alt_ff     <= '0;
         falling_ff      <= '0;
         land_run_ff     <= 1'b0;
         land_start_ff   <= '0;
         held_mag_ff     <= '0;
         rsp_changed_ff  <= 1'b0;
      end else if (adv_out) begin
         phase_ff        <= phase_in;
         launch_run_ff   <= launch_run_in;
         launch_start_ff <= launch_start_in;
         cutoff_run_ff   <= cutoff_run_in;
         cutoff_start_ff <= cutoff_start_in;
         last_check_ff   <= last_check_in;
         prev_alt_ff     <= prev_alt_in;
         falling_ff      <= falling_in;
         land_run_ff     <= land_run_in;
         land_start_ff   <= land_start_in;
         held_mag_ff     <= held_mag_in;
         rsp_changed_ff  <= (phase_in != phase_ff);
      end
   end

   // result register holds the phase after the last processed request
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_changed_ff, phase_ff};

`ifndef ASSERT_OFF
   a_landed_final: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LANDED) |=> (phase_ff == PH_LANDED))
      else $error("phase left landed");

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && phase_ff != $past(phase_ff))
         |-> (phase_ff == $past(phase_ff) + 3'd1))
      else $error("phase skipped or went back");

   a_changed_not_ground: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_changed_ff) |-> (phase_ff != PH_GROUND))
      else $error("change reported into ground idle");

   a_held_mag: assert property (@(posedge clock) disable iff (reset)
      !(adv_out && s3_av_ff) |=> $stable(held_mag_ff))
      else $error("held magnitude changed without a valid sample");

   a_falling_phase: assert property (@(posedge clock) disable iff (reset)
      (falling_ff != '0) |-> (phase_ff == PH_COAST || phase_ff == PH_DESCEND ||
                              phase_ff == PH_LANDED))
      else $error("falling count before coasting");
`endif

endmodule

// File: test/flight_phase_detector_top_tb.sv
`timescale 1ns / 1ps

module flight_phase_detector_top_tb;
   import fpd_pkg::*;

   typedef struct {
      logic [TIME_W-1:0]         time_ms;
      logic                      accel_valid;
      logic signed [ACCEL_W-1:0] ax;
      logic signed [ACCEL_W-1:0] ay;
      logic signed [ACCEL_W-1:0] az;
      logic signed [ALT_W-1:0]   alt;
   } sensor_sample_type;

   typedef struct {
      logic [PHASE_W-1:0]      phase;
      bit                      launch_run;
      logic [TIME_W-1:0]       launch_t0;
      bit                      cutoff_run;
      logic [TIME_W-1:0]       cutoff_t0;
      logic [TIME_W-1:0]       last_check;
      logic signed [ALT_W-1:0] prev_alt;
      logic [COUNT_W-1:0]      falls;
      bit                      land_run;
      logic [TIME_W-1:0]       land_t0;
      longint                  mag_sq;
   } flight_state_type;

   typedef struct {
      logic [LEVEL_W-1:0]    launch_level;
      logic [LEVEL_W-1:0]    cutoff_level;
      logic [MS_W-1:0]       hold_ms;
      logic [MS_W-1:0]       apogee_ms;
      logic [COUNT_W-1:0]    fall_count;
      logic [LAND_ALT_W-1:0] land_level;
      logic [MS_W-1:0]       land_confirm_ms;
   } flight_cfg_type;

   typedef struct {
      logic [PHASE_W-1:0] phase;
      logic               changed;
   } phase_report_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   flight_cfg_type flight_cfg = '{RST_LAUNCH_LEVEL, RST_CUTOFF_LEVEL, RST_HOLD_TIME,
                                  RST_APOGEE_INTVL, RST_APOGEE_COUNT, RST_LAND_LEVEL,
                                  RST_LAND_CONFIRM};
   flight_state_type  live_state = '{default: 0};
   flight_state_type  plan_state = '{default: 0};
   logic [TIME_W-1:0] plan_time = '0;

   sensor_sample_type samples_to_send[$];
   phase_report_type  pending_reports[$];
   sensor_sample_type on_bus;
   phase_report_type  due;
   phase_report_type  fresh;

   int samples_taken = 0;
   int reports_seen  = 0;
   int phase_changes = 0;
   int cfg_writes    = 0;
   int mismatches    = 0;
   int send_gap;
   int recv_gap;

   flight_phase_detector_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic bit advance_flight(inout flight_state_type st,
                                         input sensor_sample_type smp);
      logic [PHASE_W-1:0] was;
      longint             lvl;
      longint             vx;
      longint             vy;
      longint             vz;
      longint             alt;
      logic [TIME_W-1:0]  dt;
      was = st.phase;
      vx  = longint'(smp.ax);
      vy  = longint'(smp.ay);
      vz  = longint'(smp.az);
      if (smp.accel_valid) st.mag_sq = vx * vx + vy * vy + vz * vz;
      case (st.phase)
         PH_GROUND: begin
            lvl = longint'(flight_cfg.launch_level);
            if (smp.accel_valid) begin
               if (st.mag_sq > lvl * lvl) begin
                  dt = smp.time_ms - st.launch_t0;
                  if (!st.launch_run) begin
                     st.launch_run = 1'b1;
                     st.launch_t0  = smp.time_ms;
                  end else if (dt >= {16'd0, flight_cfg.hold_ms}) begin
                     st.phase = PH_POWERED;
                  end
               end else begin
                  st.launch_run = 1'b0;
               end
            end
         end
         PH_POWERED: begin
            lvl = longint'(flight_cfg.cutoff_level);
            if (st.mag_sq <= lvl * lvl) begin
               dt = smp.time_ms - st.cutoff_t0;
               if (!st.cutoff_run) begin
                  st.cutoff_run = 1'b1;
                  st.cutoff_t0  = smp.time_ms;
               end else if (dt >= {16'd0, flight_cfg.hold_ms}) begin
                  st.phase = PH_COAST;
               end
            end else begin
               st.cutoff_run = 1'b0;
            end
         end
         PH_COAST: begin
            dt = smp.time_ms - st.last_check;
            if (dt >= {16'd0, flight_cfg.apogee_ms}) begin
               if (smp.alt < st.prev_alt) begin
                  if (st.falls != FALL_MAX) st.falls = st.falls + 8'd1;
                  if (st.falls >= flight_cfg.fall_count) st.phase = PH_DESCEND;
               end else begin
                  st.falls = '0;
               end
               // apogee sample leaves the altitude history alone
               if (st.phase == PH_COAST) begin
                  st.prev_alt   = smp.alt;
                  st.last_check = smp.time_ms;
               end
            end
         end
         PH_DESCEND: begin
            alt = longint'(smp.alt);
            lvl = longint'(flight_cfg.land_level);
            if (alt < lvl) begin
               dt = smp.time_ms - st.land_t0;
               if (!st.land_run) begin
                  st.land_run = 1'b1;
                  st.land_t0  = smp.time_ms;
               end else if (dt >= {16'd0, flight_cfg.land_confirm_ms}) begin
                  st.phase = PH_LANDED;
               end
            end else begin
               st.land_run = 1'b0;
            end
         end
         default: ;
      endcase
      return st.phase != was;
   endfunction

   function automatic logic signed [ACCEL_W-1:0] to_accel(input longint v);
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      return v[ACCEL_W-1:0];
   endfunction

   function automatic logic signed [ALT_W-1:0] to_alt(input longint v);
      if (v > 8388607) v = 8388607;
      else if (v < -8388608) v = -8388608;
      return v[ALT_W-1:0];
   endfunction

   function automatic logic signed [ACCEL_W-1:0] accel_near(input longint center,
                                                            input longint radius);
      longint v;
      v = longint'($urandom_range(0, 32'(2 * radius)));
      return to_accel(center - radius + v);
   endfunction

   function automatic sensor_sample_type draw_sample(input bit toward);
      sensor_sample_type smp;
      int unsigned       span;
      int unsigned       pick;
      logic [TIME_W-1:0] mark;
      longint            lvl;
      longint            a;
      longint            step;
      case (plan_state.phase)
         PH_GROUND: begin
            span = {16'd0, flight_cfg.hold_ms};
            mark = plan_state.launch_t0;
         end
         PH_POWERED: begin
            span = {16'd0, flight_cfg.hold_ms};
            mark = plan_state.cutoff_t0;
         end
         PH_COAST: begin
            span = {16'd0, flight_cfg.apogee_ms};
            mark = plan_state.last_check;
         end
         default: begin
            span = {16'd0, flight_cfg.land_confirm_ms};
            mark = plan_state.land_t0;
         end
      endcase
      // timestamps: mostly small steps, some exact timer boundaries, rare jumps
      pick = $urandom_range(0, 39);
      if (pick == 0) smp.time_ms = $urandom;
      else if (pick < 7) smp.time_ms = mark + span;
      else smp.time_ms = plan_time + $urandom_range(0, span + span / 2 + 4);

      if (plan_state.phase == PH_GROUND) lvl = longint'(flight_cfg.launch_level);
      else lvl = longint'(flight_cfg.cutoff_level);
      smp.accel_valid = ($urandom_range(0, 5) != 0);
      smp.ax = ACCEL_W'($urandom);
      smp.ay = ACCEL_W'($urandom);
      smp.az = ACCEL_W'($urandom);
      pick = $urandom_range(0, 5);
      if (toward && plan_state.phase == PH_GROUND) begin
         smp.accel_valid = 1'b1;
         step = longint'($urandom_range(0, 3000));
         a = lvl + 1 + step;
         smp.ax = to_accel(($urandom_range(0, 1) != 0) ? -a : a);
         smp.ay = accel_near(0, 2000);
         smp.az = accel_near(0, 2000);
      end else if (toward && plan_state.phase == PH_POWERED) begin
         smp.accel_valid = ($urandom_range(0, 3) != 0);
         smp.ax = accel_near(0, lvl / 2);
         smp.ay = accel_near(0, lvl / 2);
         smp.az = accel_near(0, lvl / 2);
      end else if (pick == 1 && lvl < 32767) begin
         // right at the threshold
         smp.ax = accel_near(($urandom_range(0, 1) != 0) ? -lvl : lvl, 1);
         smp.ay = '0;
         smp.az = '0;
      end else if (pick == 2) begin
         smp.ax = '0;
         smp.ay = '0;
         smp.az = '0;
      end else if (pick == 3) begin
         smp.ax = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;
         smp.ay = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;
         smp.az = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;
      end else if (pick >= 4) begin
         smp.ax = accel_near(0, 2000);
         smp.ay = accel_near(0, 2000);
         smp.az = accel_near(0, 2000);
      end

      case (plan_state.phase)
         PH_COAST:   a = longint'(plan_state.prev_alt);
         PH_DESCEND: a = longint'(flight_cfg.land_level);
         default:    a = '0;
      endcase
      if (toward && plan_state.phase inside {PH_COAST, PH_DESCEND}) begin
         step = longint'($urandom_range(0, 499));
         smp.alt = to_alt(a - 1 - step);
      end else if (!(plan_state.phase inside {PH_COAST, PH_DESCEND}) ||
                   $urandom_range(0, 19) == 0) begin
         smp.alt = ALT_W'($urandom);
      end else begin
         step = longint'($urandom_range(0, 600));
         smp.alt = to_alt(a + step - 300);
      end
      return smp;
   endfunction

   // rewrite a sample so that it keeps the flight in its current phase
   function automatic void steady(inout sensor_sample_type smp);
      case (plan_state.phase)
         PH_GROUND: begin
            smp.accel_valid = 1'b1;
            smp.ax = '0;
            smp.ay = '0;
            smp.az = '0;
         end
         PH_POWERED: begin
            smp.accel_valid = 1'b1;
            smp.ax = 16'sh8000;
            smp.ay = 16'sh8000;
            smp.az = 16'sh8000;
         end
         PH_COAST:   smp.alt = plan_state.prev_alt;
         PH_DESCEND: smp.alt = 24'sh7fffff;
         default: ;
      endcase
   endfunction

   task automatic send(input sensor_sample_type smp);
      void'(advance_flight(plan_state, smp));
      plan_time = smp.time_ms;
      samples_to_send.push_back(smp);
   endtask

   task automatic fly(input logic [PHASE_W-1:0] ph, input int n_hold, input int n_push);
      sensor_sample_type smp;
      flight_state_type  trial;
      int                i;
      i = 0;
      while (i < n_hold + n_push && plan_state.phase == ph) begin
         smp   = draw_sample(i >= n_hold);
         trial = plan_state;
         if (i < n_hold && advance_flight(trial, smp)) steady(smp);
         send(smp);
         i++;
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (samples_to_send.size() != 0 || req_tvalid || pending_reports.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      case (idx)
         CSR_LAUNCH_LEVEL: flight_cfg.launch_level    = val[LEVEL_W-1:0];
         CSR_CUTOFF_LEVEL: flight_cfg.cutoff_level    = val[LEVEL_W-1:0];
         CSR_HOLD_TIME:    flight_cfg.hold_ms         = val[MS_W-1:0];
         CSR_APOGEE_INTVL: flight_cfg.apogee_ms       = val[MS_W-1:0];
         CSR_APOGEE_COUNT: flight_cfg.fall_count      = val[COUNT_W-1:0];
         CSR_LAND_LEVEL:   flight_cfg.land_level      = val[LAND_ALT_W-1:0];
         CSR_LAND_CONFIRM: flight_cfg.land_confirm_ms = val[MS_W-1:0];
         default: ;
      endcase
      cfg_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_fields(input logic [TIME_W-1:0] t, input logic valid,
                              input int x, input int y, input int z, input int alt);
      sensor_sample_type smp;
      smp.time_ms     = t;
      smp.accel_valid = valid;
      smp.ax          = x[ACCEL_W-1:0];
      smp.ay          = y[ACCEL_W-1:0];
      smp.az          = z[ACCEL_W-1:0];
      smp.alt         = alt[ALT_W-1:0];
      send(smp);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         send_gap = (samples_taken < 480) ? 18 : (samples_taken < 960) ? 87 : 0;
         if (req_tvalid && req_tready) begin
            fresh.changed = advance_flight(live_state, on_bus);
            fresh.phase   = live_state.phase;
            pending_reports.push_back(fresh);
            phase_changes += int'(fresh.changed);
            samples_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap) begin
               on_bus      = samples_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {on_bus.alt, on_bus.az, on_bus.ay, on_bus.ax, on_bus.time_ms};
               req_tuser  <= on_bus.accel_valid;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         recv_gap = (reports_seen < 480) ? 87 : (reports_seen < 960) ? 18 : 0;
         if (rsp_tvalid && rsp_tready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, got phase %0d changed %0b",
                        $time, rsp_tdata[2:0], rsp_tdata[3]);
            end else begin
               due = pending_reports.pop_front();
               if (rsp_tdata[2:0] !== due.phase) begin
                  mismatches++;
                  $display("%0t: phase expected %0d got %0d", $time, due.phase,
                           rsp_tdata[2:0]);
               end
               if (rsp_tdata[3] !== due.changed) begin
                  mismatches++;
                  $display("%0t: phase_changed expected %0b got %0b", $time, due.changed,
                           rsp_tdata[3]);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_gap);
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ground: invalid readings, wrapped timer, threshold equality
      send_fields(32'h0000_0000, 1'b1, 0, 0, 0, 0);
      send_fields(32'h0000_0005, 1'b0, -32768, -32768, -32768, -8388608);
      send_fields(32'hffff_fff0, 1'b1, -32768, -32768, -32768, 8388607);
      send_fields(32'h0000_0010, 1'b0, 32767, 32767, 32767, 0);
      send_fields(32'h0000_0050, 1'b1, 32767, 32767, 32767, -1);
      send_fields(32'h0000_0060, 1'b1, 3000, 0, 0, 1);
      send_fields(32'h0000_0061, 1'b1, 0, -3001, 0, 100);
      send_fields(32'h0000_0062, 1'b1, 0, 0, 2999, -100);

      wait_idle();
      write_reg(CSR_LAUNCH_LEVEL, 65535);
      write_reg(CSR_HOLD_TIME, 65535);
      fly(PH_GROUND, 120, 0);
      wait_idle();
      write_reg(CSR_LAUNCH_LEVEL, 0);
      write_reg(CSR_HOLD_TIME, 0);
      fly(PH_GROUND, 60, 0);
      wait_idle();
      write_reg(CSR_LAUNCH_LEVEL, $urandom_range(1500, 20000));
      write_reg(CSR_HOLD_TIME, $urandom_range(0, 300));
      fly(PH_GROUND, 150, 300);
      wait_idle();
      write_reg(CSR_LAUNCH_LEVEL, 0);
      write_reg(CSR_HOLD_TIME, 0);
      fly(PH_GROUND, 0, 50);

      wait_idle();
      write_reg(CSR_CUTOFF_LEVEL, 0);
      write_reg(CSR_HOLD_TIME, 65535);
      fly(PH_POWERED, 100, 0);
      wait_idle();
      write_reg(CSR_CUTOFF_LEVEL, $urandom_range(500, 20000));
      write_reg(CSR_HOLD_TIME, $urandom_range(0, 400));
      fly(PH_POWERED, 150, 300);
      wait_idle();
      write_reg(CSR_CUTOFF_LEVEL, 65535);
      write_reg(CSR_HOLD_TIME, 0);
      fly(PH_POWERED, 0, 50);

      wait_idle();
      write_reg(CSR_APOGEE_INTVL, 65535);
      write_reg(CSR_APOGEE_COUNT, 1);
      fly(PH_COAST, 40, 0);
      wait_idle();
      write_reg(CSR_APOGEE_INTVL, $urandom_range(0, 150));
      write_reg(CSR_APOGEE_COUNT, $urandom_range(1, 8));
      fly(PH_COAST, 200, 0);
      wait_idle();
      write_reg(CSR_APOGEE_INTVL, 0);
      write_reg(CSR_APOGEE_COUNT, 255);
      fly(PH_COAST, 0, 400);
      wait_idle();
      write_reg(CSR_APOGEE_COUNT, 1);
      fly(PH_COAST, 0, 50);

      wait_idle();
      write_reg(CSR_LAND_LEVEL, 0);
      write_reg(CSR_LAND_CONFIRM, 65535);
      fly(PH_DESCEND, 80, 0);
      wait_idle();
      write_reg(CSR_LAND_LEVEL, $urandom_range(0, 2000));
      write_reg(CSR_LAND_CONFIRM, $urandom_range(0, 6000));
      fly(PH_DESCEND, 120, 300);
      wait_idle();
      write_reg(CSR_LAND_LEVEL, 8388607);
      write_reg(CSR_LAND_CONFIRM, 0);
      fly(PH_DESCEND, 0, 50);

      // landed is final whatever the settings
      wait_idle();
      write_reg(CSR_LAUNCH_LEVEL, $urandom_range(0, 65535));
      write_reg(CSR_CUTOFF_LEVEL, $urandom_range(0, 65535));
      write_reg(CSR_HOLD_TIME, $urandom_range(0, 65535));
      write_reg(CSR_APOGEE_INTVL, $urandom_range(0, 65535));
      write_reg(CSR_APOGEE_COUNT, $urandom_range(1, 255));
      write_reg(CSR_LAND_LEVEL, $urandom_range(0, 8388607));
      write_reg(CSR_LAND_CONFIRM, $urandom_range(0, 65535));
      fly(PH_LANDED, 100, 0);
      wait_idle();

      $display("flew %0d sensor samples through %0d phase changes, ending in phase %0d",
               samples_taken, phase_changes, live_state.phase);
      $display("%0d register writes across the flight, %0d mismatches",
               cfg_writes, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
